// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the timer RTL; clk and rst are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TMOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle
`define TMOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tmoc_pkg.sv =====
// Types, register indexes and opcodes of the timer with output compares.
package tmoc_pkg;

  localparam int NUM_CMP   = 5;
  localparam int TDIV_W    = 13;
  localparam int RTIDIV_W  = 3;
  localparam int CNT_W     = 16;
  localparam int PCNT_W    = 8;
  localparam int PORT_W    = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Opcodes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_WR_CMP    = 2'd1;
  localparam logic [1:0] OP_WR_PULSE  = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RTI_RATE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OC1_MASK  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OC1_DATA  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CMP_MODES = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_GATED_EN  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_GATE_LVL  = 3'd6;

  // Compare pin action codes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_TOGGLE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_SET    = 2'd3;

  typedef struct packed {
    logic [1:0]        prescale_select;
    logic [1:0]        rti_rate;
    logic [PORT_W-1:0] oc1_mask;
    logic [PORT_W-1:0] oc1_data;
    logic [7:0]        compare_modes;
    logic              gated_enable;
    logic              gate_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       compare_index;
    logic [CNT_W-1:0] write_value;
    logic             pa7_level;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0]  port_out;
    logic               pulse_overflow_event;
    logic [PCNT_W-1:0]  pulse_count;
    logic [NUM_CMP-1:0] match_events;
    logic               rti_event;
    logic               overflow_event;
    logic [CNT_W-1:0]   timer_count;
  } res_t;

endpackage

// ===== rtl/core/tmoc_cfg.sv =====
// Configuration register bank of the timer.
module tmoc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tmoc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tmoc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tmoc_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tmoc_pkg::REG_PRESCALE:  cfg.prescale_select <= cfg_wdata[1:0];
        tmoc_pkg::REG_RTI_RATE:  cfg.rti_rate        <= cfg_wdata[1:0];
        tmoc_pkg::REG_OC1_MASK:  cfg.oc1_mask        <= cfg_wdata[tmoc_pkg::PORT_W-1:0];
        tmoc_pkg::REG_OC1_DATA:  cfg.oc1_data        <= cfg_wdata[tmoc_pkg::PORT_W-1:0];
        tmoc_pkg::REG_CMP_MODES: cfg.compare_modes   <= cfg_wdata;
        tmoc_pkg::REG_GATED_EN:  cfg.gated_enable    <= cfg_wdata[0];
        tmoc_pkg::REG_GATE_LVL:  cfg.gate_level      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/tmoc_core.sv =====
// Timer state and per-item update: dividers, counters, compares and port bits.
`include "assert_macros.svh"

module tmoc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  tmoc_pkg::item_t     item,
  input  tmoc_pkg::cfg_t      cfg,
  output tmoc_pkg::res_t      res
);

  logic [tmoc_pkg::TDIV_W-1:0]   tick_divider, tick_divider_next;
  logic [tmoc_pkg::RTIDIV_W-1:0] rti_divider, rti_divider_next;
  logic [tmoc_pkg::CNT_W-1:0]    free_counter, free_counter_next;
  logic [tmoc_pkg::PCNT_W-1:0]   pulse_counter, pulse_counter_next;
  logic [tmoc_pkg::PORT_W-1:0]   port_bits, port_bits_next;
  logic [tmoc_pkg::CNT_W-1:0]    compare_values [tmoc_pkg::NUM_CMP];

  logic                          tick;
  logic                          step;
  logic                          pulse_step;
  logic [tmoc_pkg::NUM_CMP-1:0]  cmp_hit;
  logic [tmoc_pkg::PORT_W-1:0]   oc1_port;

  assign tick = item.opcode == tmoc_pkg::OP_TICK;

  always_comb begin
    tick_divider_next  = tick_divider + 1'b1;
    rti_divider_next   = rti_divider;
    free_counter_next  = free_counter;
    pulse_counter_next = pulse_counter;
    res                = '0;

    case (cfg.prescale_select)
      2'd1:    step = tick_divider_next[1:0] == '0;
      2'd2:    step = tick_divider_next[2:0] == '0;
      2'd3:    step = tick_divider_next[3:0] == '0;
      default: step = 1'b1;
    endcase

    pulse_step = cfg.gated_enable && (tick_divider_next[5:0] == '0) &&
                 (item.pa7_level == cfg.gate_level);

    if (tick) begin
      if (step) begin
        free_counter_next  = free_counter + 1'b1;
        res.overflow_event = free_counter_next == '0;
      end
      if (tick_divider_next == '0) begin
        rti_divider_next = rti_divider + 1'b1;
        case (cfg.rti_rate)
          2'd1:    res.rti_event = rti_divider_next[0] == 1'b0;
          2'd2:    res.rti_event = rti_divider_next[1:0] == '0;
          2'd3:    res.rti_event = rti_divider_next == '0;
          default: res.rti_event = 1'b1;
        endcase
      end
      if (pulse_step) begin
        pulse_counter_next       = pulse_counter + 1'b1;
        res.pulse_overflow_event = pulse_counter_next == '0;
      end
    end else if (item.opcode == tmoc_pkg::OP_WR_PULSE) begin
      pulse_counter_next = item.write_value[tmoc_pkg::PCNT_W-1:0];
    end

    for (int i = 0; i < tmoc_pkg::NUM_CMP; i++) begin
      cmp_hit[i] = tick && (free_counter_next == compare_values[i]);
    end

    // Compare 1 forces its masked bits and locks out the other compares on them
    oc1_port = cmp_hit[0] ? ((port_bits & ~cfg.oc1_mask) | (cfg.oc1_data & cfg.oc1_mask))
                          : port_bits;
    port_bits_next = oc1_port;
    // Compare k+1 drives bit 4-k, its mode sits at bits 2b+1:2b for bit b
    for (int b = 0; b < tmoc_pkg::PORT_W - 1; b++) begin
      if (cmp_hit[tmoc_pkg::PORT_W-1-b] && !(cmp_hit[0] && cfg.oc1_mask[b])) begin
        case (cfg.compare_modes[2*b +: 2])
          tmoc_pkg::MODE_TOGGLE: port_bits_next[b] = ~port_bits[b];
          tmoc_pkg::MODE_CLEAR:  port_bits_next[b] = 1'b0;
          tmoc_pkg::MODE_SET:    port_bits_next[b] = 1'b1;
          default:               port_bits_next[b] = oc1_port[b];
        endcase
      end
    end

    res.timer_count  = free_counter_next;
    res.match_events = cmp_hit;
    res.pulse_count  = pulse_counter_next;
    res.port_out     = port_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider  <= '0;
      rti_divider   <= '0;
      free_counter  <= '0;
      pulse_counter <= '0;
      port_bits     <= '0;
      for (int i = 0; i < tmoc_pkg::NUM_CMP; i++) begin
        compare_values[i] <= '1;
      end
    end else if (fire) begin
      if (tick) begin
        tick_divider <= tick_divider_next;
        rti_divider  <= rti_divider_next;
      end
      free_counter  <= free_counter_next;
      pulse_counter <= pulse_counter_next;
      port_bits     <= port_bits_next;
      if (item.opcode == tmoc_pkg::OP_WR_CMP &&
          item.compare_index < 3'(tmoc_pkg::NUM_CMP)) begin
        compare_values[item.compare_index] <= item.write_value;
      end
    end
  end

  `TMOC_ASSERT_NXT(a_write_holds_counter, fire && !tick, $stable(free_counter), "counter moved on a write item")
  `TMOC_ASSERT_NXT(a_oc1_forces_port, fire && cmp_hit[0], (port_bits & $past(cfg.oc1_mask)) == ($past(cfg.oc1_data) & $past(cfg.oc1_mask)), "compare 1 did not force its masked bits")
  `TMOC_ASSERT_NXT(a_pulse_wrap, fire && res.pulse_overflow_event, pulse_counter == '0, "pulse wrap left a non-zero count")
  `TMOC_ASSERT_NOW(a_events_on_tick, fire && !tick, res.overflow_event == 1'b0 && res.rti_event == 1'b0 && res.match_events == '0, "event raised on a non-tick item")

endmodule

// ===== rtl/core/timer_with_output_compares.sv =====
// Top level of the timer with output compares: stream registers around the timer core.
//
//   channel  dir  contents
//   s_*      in   tuser: opcode; tdata: compare_index, write_value, pa7_level
//   m_*      out  tdata: timer_count .. port_out, one result per item
//   cfg_*    in   register writes, index 0..6
//
// One item per cycle while m_* is not stalled; an item transferred on s_* is held in the
// input register, and its result is loaded into the result register and offered on m_*.
// The whole update of the timer state is one pass of logic between those registers.
// rst is synchronous and clears the valid flags and all timer and configuration state,
// compares to all ones. A stalled output holds the result register and the input
// register, and s_tready drops only while both are full.
module timer_with_output_compares (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // opcode[1:0]
  input  logic [1:0]                         s_tuser,
  // compare_index[2:0], write_value[18:3], pa7_level[19], zero pad
  input  logic [tmoc_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // timer_count[15:0], overflow_event[16], rti_event[17], match_events[22:18],
  // pulse_count[30:23], pulse_overflow_event[31], port_out[36:32], zero pad
  output logic [tmoc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_we,
  input  logic [tmoc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tmoc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  tmoc_pkg::cfg_t  cfg;
  tmoc_pkg::item_t in_item;
  tmoc_pkg::res_t  res;
  tmoc_pkg::res_t  out_res;
  logic            in_valid;
  logic            advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.opcode        <= s_tuser;
      in_item.compare_index <= s_tdata[2:0];
      in_item.write_value   <= s_tdata[18:3];
      in_item.pa7_level     <= s_tdata[19];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res};

  tmoc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tmoc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

// ===== sim/tb_timer_with_output_compares.sv =====
// Self-checking testbench for the timer with output compares: directed, tick-run and random tests.
`timescale 1ns / 100ps

module tb_timer_with_output_compares;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [1:0]                       s_tuser = tmoc_pkg::OP_TICK;
  logic [tmoc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [tmoc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_we = 1'b0;
  logic [tmoc_pkg::CFG_ADDR_W-1:0]  cfg_addr = tmoc_pkg::REG_PRESCALE;
  logic [tmoc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  timer_with_output_compares u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Timer state as the block should hold it
  tmoc_pkg::cfg_t cfg = '0;
  logic [12:0] tick_div = '0;
  logic [2:0]  rti_div = '0;
  logic [15:0] free_cnt = '0;
  logic [7:0]  pulse_cnt = '0;
  logic [4:0]  port_q = '0;
  logic [15:0] cmp_val [tmoc_pkg::NUM_CMP];

  tmoc_pkg::res_t pending_readings [$];
  int   fail_count = 0;
  int   mismatch_count = 0;
  int   burst_left = 0;
  logic [11:0] rx_ctr = '0;

  task automatic advance_timer(input tmoc_pkg::item_t it, output tmoc_pkg::res_t r);
    logic       step;
    logic [2:0] rti_mask;
    logic [4:0] blocked;
    logic [1:0] mode;
    int         pin;
    r = '0;
    blocked = '0;
    case (it.opcode)
      tmoc_pkg::OP_WR_CMP: begin
        if (it.compare_index < tmoc_pkg::NUM_CMP) cmp_val[it.compare_index] = it.write_value;
      end
      tmoc_pkg::OP_WR_PULSE: begin
        pulse_cnt = it.write_value[7:0];
      end
      tmoc_pkg::OP_TICK: begin
        tick_div = tick_div + 13'd1;
        case (cfg.prescale_select)
          2'd1: step = (tick_div[1:0] == 2'd0);
          2'd2: step = (tick_div[2:0] == 3'd0);
          2'd3: step = (tick_div[3:0] == 4'd0);
          default: step = 1'b1;
        endcase
        if (step) begin
          free_cnt = free_cnt + 16'd1;
          r.overflow_event = (free_cnt == 16'd0);
        end
        if (tick_div == 13'd0) begin
          rti_div = rti_div + 3'd1;
          rti_mask = ~(3'b111 << cfg.rti_rate);
          r.rti_event = ((rti_div & rti_mask) == 3'd0);
        end
        if (cfg.gated_enable && tick_div[5:0] == 6'd0 && it.pa7_level == cfg.gate_level) begin
          pulse_cnt = pulse_cnt + 8'd1;
          r.pulse_overflow_event = (pulse_cnt == 8'd0);
        end
        // compare 1 wins on every pin it masks
        if (free_cnt == cmp_val[0]) begin
          r.match_events[0] = 1'b1;
          port_q = (port_q & ~cfg.oc1_mask) | (cfg.oc1_data & cfg.oc1_mask);
          blocked = cfg.oc1_mask;
        end
        for (int k = 1; k < tmoc_pkg::NUM_CMP; k++) begin
          pin = 4 - k;
          if (free_cnt == cmp_val[k]) begin
            r.match_events[k] = 1'b1;
            mode = 2'((cfg.compare_modes >> (8 - 2 * k)) & 8'd3);
            if (!blocked[pin]) begin
              case (mode)
                tmoc_pkg::MODE_TOGGLE: port_q[pin] = ~port_q[pin];
                tmoc_pkg::MODE_CLEAR:  port_q[pin] = 1'b0;
                tmoc_pkg::MODE_SET:    port_q[pin] = 1'b1;
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase
    r.timer_count = free_cnt;
    r.pulse_count = pulse_cnt;
    r.port_out    = port_q;
  endtask

  // One item onto the input stream; prediction is taken at the transfer
  task automatic send_timer_item(input logic [1:0] op, input logic [2:0] idx,
                                 input logic [15:0] val, input logic pa7);
    tmoc_pkg::item_t it;
    tmoc_pkg::res_t  r;
    it.opcode = op;
    it.compare_index = idx;
    it.write_value = val;
    it.pa7_level = pa7;
    s_tuser  <= op;
    s_tdata  <= {4'b0, pa7, val, idx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    advance_timer(it, r);
    pending_readings.push_back(r);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input tmoc_pkg::cfg_t c);
    logic [tmoc_pkg::CFG_DATA_W-1:0] vals [7];
    vals[tmoc_pkg::REG_PRESCALE]  = 8'(c.prescale_select);
    vals[tmoc_pkg::REG_RTI_RATE]  = 8'(c.rti_rate);
    vals[tmoc_pkg::REG_OC1_MASK]  = 8'(c.oc1_mask);
    vals[tmoc_pkg::REG_OC1_DATA]  = 8'(c.oc1_data);
    vals[tmoc_pkg::REG_CMP_MODES] = c.compare_modes;
    vals[tmoc_pkg::REG_GATED_EN]  = 8'(c.gated_enable);
    vals[tmoc_pkg::REG_GATE_LVL]  = 8'(c.gate_level);
    for (int a = 0; a < 7; a++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= tmoc_pkg::CFG_ADDR_W'(a);
      cfg_wdata <= vals[a];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  function automatic tmoc_pkg::cfg_t random_cfg();
    tmoc_pkg::cfg_t c;
    c.prescale_select = 2'($urandom);
    c.rti_rate        = 2'($urandom);
    c.oc1_mask        = 5'($urandom);
    c.oc1_data        = 5'($urandom);
    c.compare_modes   = 8'($urandom);
    c.gated_enable    = 1'($urandom);
    c.gate_level      = 1'($urandom);
    return c;
  endfunction

  // Compare writes, ignored indexes, pulse write, unused opcode, then
  // simultaneous matches where compare 1 overrides compare 2
  task automatic test_writes_and_override();
    tmoc_pkg::cfg_t c;
    c.prescale_select = 2'd0;
    c.rti_rate        = 2'd0;
    c.oc1_mask        = 5'b01001;
    c.oc1_data        = 5'b01000;
    c.compare_modes   = {tmoc_pkg::MODE_SET, tmoc_pkg::MODE_TOGGLE,
                         tmoc_pkg::MODE_CLEAR, tmoc_pkg::MODE_TOGGLE};
    c.gated_enable    = 1'b1;
    c.gate_level      = 1'b1;
    set_config(c);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd0, 16'd2, 1'b0);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd1, 16'd2, 1'b1);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd2, 16'd2, 1'b0);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd3, 16'd3, 1'b1);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd4, 16'd3, 1'b0);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd7, 16'hFFFF, 1'b1);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd5, 16'h0000, 1'b0);
    send_timer_item(tmoc_pkg::OP_WR_PULSE, 3'd0, 16'hAAFF, 1'b0);
    send_timer_item(OP_UNUSED, 3'd7, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_timer_item(tmoc_pkg::OP_TICK, 3'd0, 16'h0000, 1'(i));
    wait_idle();
  endtask

  // Counter held by the prescaler keeps matching the same compare
  task automatic test_prescaled_repeat_match();
    tmoc_pkg::cfg_t c;
    c = cfg;
    c.prescale_select = 2'd3;
    set_config(c);
    send_timer_item(tmoc_pkg::OP_WR_CMP, 3'd4, free_cnt + 16'd1, 1'b0);
    for (int i = 0; i < 10; i++) send_timer_item(tmoc_pkg::OP_TICK, 3'd0, 16'h0000, 1'b1);
    wait_idle();
  endtask

  // Tick runs at every real-time rate, with a gated pulse count brought up to its wrap
  task automatic test_rti_and_wraps();
    tmoc_pkg::cfg_t c;
    for (int rate = 0; rate < 4; rate++) begin
      c = random_cfg();
      c.prescale_select = 2'd0;
      c.rti_rate        = 2'(rate);
      c.gated_enable    = 1'b1;
      set_config(c);
      send_timer_item(tmoc_pkg::OP_WR_PULSE, 3'd0, 16'h00FF, 1'b0);
      for (int i = 0; i < 64; i++)
        send_timer_item(tmoc_pkg::OP_TICK, 3'($urandom), 16'($urandom),
                        ($urandom_range(0, 7) != 0) ? c.gate_level : ~c.gate_level);
      wait_idle();
    end
  endtask

  task automatic test_random_mix();
    tmoc_pkg::cfg_t c;
    int          pick;
    logic [15:0] val;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) c = '1;
      else if (phase == 1) c = '0;
      else c = random_cfg();
      set_config(c);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_timer_item(tmoc_pkg::OP_TICK, 3'($urandom), 16'($urandom), 1'($urandom));
        end else if (pick < 85) begin
          // mostly near the counter so matches are frequent
          val = ($urandom_range(0, 3) == 0) ? 16'($urandom) : free_cnt + 16'($urandom_range(0, 6));
          send_timer_item(tmoc_pkg::OP_WR_CMP,
                          ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                                                        3'($urandom_range(0, 4)),
                          val, 1'($urandom));
        end else if (pick < 95) begin
          val = 16'($urandom);
          if ($urandom_range(0, 1) == 0) val[7:0] = 8'hFF - 8'($urandom_range(0, 3));
          send_timer_item(tmoc_pkg::OP_WR_PULSE, 3'($urandom), val, 1'($urandom));
        end else begin
          send_timer_item(OP_UNUSED, 3'($urandom), 16'($urandom), 1'($urandom));
        end
      end
      wait_idle();
    end
  endtask

  // Receiver stall pattern: free-running, then alternate, sparse and heavy stalls
  always @(posedge clk) begin
    rx_ctr <= rx_ctr + 12'd1;
    case (rx_ctr[11:10])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= rx_ctr[0];
      2'd2: m_tready <= (rx_ctr[2:0] != 3'd5);
      default: m_tready <= (rx_ctr[3:0] < 4'd4);
    endcase
  end

  always @(posedge clk) begin
    tmoc_pkg::res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.timer_count          = m_tdata[15:0];
      got.overflow_event       = m_tdata[16];
      got.rti_event            = m_tdata[17];
      got.match_events         = m_tdata[22:18];
      got.pulse_count          = m_tdata[30:23];
      got.pulse_overflow_event = m_tdata[31];
      got.port_out             = m_tdata[36:32];
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("unexpected result transfer at %0t: %h", $realtime, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        if (got.timer_count !== want.timer_count || got.overflow_event !== want.overflow_event ||
            got.rti_event !== want.rti_event || got.match_events !== want.match_events ||
            got.pulse_count !== want.pulse_count ||
            got.pulse_overflow_event !== want.pulse_overflow_event ||
            got.port_out !== want.port_out) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("mismatch at %0t: cnt %h/%h ovf %b/%b rti %b/%b match %b/%b pcnt %h/%h pov %b/%b port %b/%b (exp/got)",
                     $realtime, want.timer_count, got.timer_count,
                     want.overflow_event, got.overflow_event, want.rti_event, got.rti_event,
                     want.match_events, got.match_events, want.pulse_count, got.pulse_count,
                     want.pulse_overflow_event, got.pulse_overflow_event,
                     want.port_out, got.port_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < tmoc_pkg::NUM_CMP; i++) cmp_val[i] = 16'hFFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_writes_and_override();
    test_prescaled_repeat_match();
    test_rti_and_wraps();
    test_random_mix();
    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_readings.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
